/* design/cfs_pkg.sv */
package cfs_pkg;

	localparam int ELEM_W     = 32;
	localparam int COUNT_W    = 24;
	localparam int SS_W       = 64;
	localparam int ACC_W      = 64;
	localparam int HALF_W     = ACC_W / 2;
	localparam int HCNT_W     = COUNT_W + 1;
	localparam int SIZE_W     = 32;
	localparam int DEN_W      = 2 * HCNT_W;
	localparam int SN_W       = SS_W + HCNT_W;
	localparam int DIVD_W     = SN_W + 1;
	localparam int REM_W      = DEN_W + 1;
	localparam int DIV_CNT_W  = $clog2(DIVD_W);
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = QPTR_W + 1;

	typedef struct packed {
		logic signed [ELEM_W-1:0] ls_elem;
		logic signed [ELEM_W-1:0] pt_elem;
		logic                     with_point;
		logic [COUNT_W-1:0]       point_count;
		logic [SS_W-1:0]          square_sum;
		logic                     last_elem;
	} item_t;

	typedef struct packed {
		logic [SIZE_W-1:0] cluster_size;
		logic              degenerate;
		logic              saturated;
	} result_t;

	typedef struct packed {
		item_t item;
		logic  first;
	} qentry_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DEN_W-1:0]  divisor;
	} root_req_t;

	typedef struct packed {
		logic              done;
		logic              overflow;
		logic [SIZE_W-1:0] root;
	} root_rsp_t;

endpackage

/* design/cfs_front.sv */
module cfs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cfs_pkg::item_t    item,
	output logic              busy,
	input  logic              pop,
	output cfs_pkg::qentry_t  head,
	output logic              empty
);

	cfs_pkg::qentry_t                mem_q [cfs_pkg::QDEPTH];
	logic [cfs_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [cfs_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [cfs_pkg::QCNT_W-1:0]      cnt_q;
	logic                            first_q;
	logic                            push;
	cfs_pkg::qentry_t                new_entry;

	assign busy      = (cnt_q == cfs_pkg::QCNT_W'(cfs_pkg::QDEPTH));
	assign empty     = (cnt_q == '0);
	assign push      = start && !busy;
	assign head      = mem_q[rd_ptr_q];
	assign new_entry = '{item: item, first: first_q};

	// The first item of a vector is marked here; it opens a new feature in the back end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			first_q  <= 1'b1;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
				first_q  <= item.last_elem;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_entry;
		end
	end

endmodule

/* design/cfs_root.sv */
module cfs_root (
	input  logic                clk,
	input  logic                arst_n,
	input  cfs_pkg::root_req_t  req,
	output cfs_pkg::root_rsp_t  rsp
);

	localparam logic [1:0] R_IDLE = 2'd0;
	localparam logic [1:0] R_DIV  = 2'd1;
	localparam logic [1:0] R_CHK  = 2'd2;
	localparam logic [1:0] R_SQRT = 2'd3;

	logic [1:0]                      state_q;
	logic [cfs_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [cfs_pkg::DIVD_W-1:0]      dq_q;
	logic [cfs_pkg::REM_W-1:0]       rem_q;
	logic [cfs_pkg::DEN_W-1:0]       den_q;
	logic [cfs_pkg::ACC_W-1:0]       x_q;
	logic [cfs_pkg::ACC_W-1:0]       res_q;
	logic [cfs_pkg::ACC_W-1:0]       bit_q;
	logic                            done_q;
	logic                            ovf_q;
	logic [cfs_pkg::SIZE_W-1:0]      root_q;

	logic [cfs_pkg::REM_W-1:0]       rem_sh;
	logic                            rem_ge;
	logic [cfs_pkg::ACC_W-1:0]       trial;
	logic                            x_ge;
	logic [cfs_pkg::ACC_W-1:0]       res_n;

	assign rem_sh = {rem_q[cfs_pkg::REM_W-2:0], dq_q[cfs_pkg::DIVD_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, den_q});
	assign trial  = res_q + bit_q;
	assign x_ge   = (x_q >= trial);
	assign res_n  = x_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);

	assign rsp = '{done: done_q, overflow: ovf_q, root: root_q};

	// Restoring division one quotient bit a cycle, then, unless the quotient overflows, a digit-by-digit square root.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				R_IDLE: begin
					if (req.start) begin
						cnt_q   <= '0;
						state_q <= R_DIV;
					end
				end
				R_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == cfs_pkg::DIV_CNT_W'(cfs_pkg::DIVD_W - 1)) begin
						state_q <= R_CHK;
					end
				end
				R_CHK: begin
					if (|dq_q[cfs_pkg::DIVD_W-1:cfs_pkg::ACC_W]) begin
						done_q  <= 1'b1;
						state_q <= R_IDLE;
					end else begin
						state_q <= R_SQRT;
					end
				end
				R_SQRT: begin
					if (bit_q[0]) begin
						done_q  <= 1'b1;
						state_q <= R_IDLE;
					end
				end
				default: begin
					state_q <= R_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			R_IDLE: begin
				dq_q  <= req.dividend;
				den_q <= req.divisor;
				rem_q <= '0;
			end
			R_DIV: begin
				rem_q <= rem_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
				dq_q  <= {dq_q[cfs_pkg::DIVD_W-2:0], rem_ge};
			end
			R_CHK: begin
				ovf_q  <= |dq_q[cfs_pkg::DIVD_W-1:cfs_pkg::ACC_W];
				root_q <= '1;
				x_q    <= dq_q[cfs_pkg::ACC_W-1:0];
				res_q  <= '0;
				bit_q  <= cfs_pkg::ACC_W'(1) << (cfs_pkg::ACC_W - 2);
			end
			R_SQRT: begin
				if (x_ge) begin
					x_q <= x_q - trial;
				end
				res_q  <= res_n;
				bit_q  <= bit_q >> 2;
				root_q <= res_n[cfs_pkg::SIZE_W-1:0];
			end
			default: begin
				root_q <= '1;
			end
		endcase
	end

endmodule

/* design/cfs_back.sv */
module cfs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data,
	input  cfs_pkg::qentry_t    head,
	input  logic                empty,
	output logic                pop,
	output cfs_pkg::root_req_t  root_req,
	input  cfs_pkg::root_rsp_t  root_rsp,
	output logic                done,
	output cfs_pkg::result_t    result
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SQ_LS  = 4'd1;
	localparam logic [3:0] S_ACC_LS = 4'd2;
	localparam logic [3:0] S_ACC_PT = 4'd3;
	localparam logic [3:0] S_FIN    = 4'd4;
	localparam logic [3:0] S_MUL_LO = 4'd5;
	localparam logic [3:0] S_MUL_HI = 4'd6;
	localparam logic [3:0] S_SUM    = 4'd7;
	localparam logic [3:0] S_SUB    = 4'd8;
	localparam logic [3:0] S_ROOT   = 4'd9;

	logic [3:0]                     state_q;
	logic                           mode_q;
	logic                           held_wp_q;
	logic [cfs_pkg::HCNT_W-1:0]     held_cnt_q;
	logic [cfs_pkg::SS_W-1:0]       held_ss_q;
	logic [cfs_pkg::ACC_W-1:0]      ls_acc_q;
	logic [cfs_pkg::ACC_W-1:0]      pt_acc_q;
	logic                           ovf_q;
	logic                           last_q;
	logic [cfs_pkg::ELEM_W-1:0]     ls_mag_q;
	logic [cfs_pkg::ELEM_W-1:0]     pt_mag_q;
	logic [cfs_pkg::ACC_W-1:0]      prod_q;
	logic [cfs_pkg::SS_W-1:0]       ss_q;
	logic [cfs_pkg::SN_W-1:0]       sn_q;
	logic [cfs_pkg::DEN_W-1:0]      den_q;
	logic                           done_q;
	cfs_pkg::result_t               result_q;

	logic                           wp;
	logic [cfs_pkg::ELEM_W:0]       sum_w;
	logic                           sum_ovf;
	logic [cfs_pkg::ELEM_W-1:0]     sum_sat;
	logic [cfs_pkg::ELEM_W-1:0]     sum_mag;
	logic [cfs_pkg::ELEM_W-1:0]     pt_mag;
	logic [cfs_pkg::HALF_W-1:0]     mul_a;
	logic [cfs_pkg::HALF_W-1:0]     mul_b;
	logic [cfs_pkg::ACC_W-1:0]      mul_p;
	logic [cfs_pkg::ACC_W:0]        ls_add;
	logic [cfs_pkg::ACC_W:0]        pt_add;
	logic [cfs_pkg::ACC_W:0]        ss_add;
	logic [cfs_pkg::HCNT_W-1:0]     den_b;
	logic [cfs_pkg::SN_W-1:0]       acc_ext;
	logic [cfs_pkg::SN_W-1:0]       diff;

	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;
	assign pop       = (state_q == S_IDLE) && !empty;

	assign wp      = head.first ? head.item.with_point : held_wp_q;
	assign sum_w   = {head.item.ls_elem[cfs_pkg::ELEM_W-1], head.item.ls_elem}
		+ (wp ? {head.item.pt_elem[cfs_pkg::ELEM_W-1], head.item.pt_elem}
		      : {(cfs_pkg::ELEM_W + 1){1'b0}});
	assign sum_ovf = sum_w[cfs_pkg::ELEM_W] != sum_w[cfs_pkg::ELEM_W-1];
	assign sum_sat = sum_ovf ? {sum_w[cfs_pkg::ELEM_W], {(cfs_pkg::ELEM_W - 1){!sum_w[cfs_pkg::ELEM_W]}}}
		: sum_w[cfs_pkg::ELEM_W-1:0];
	assign sum_mag = sum_sat[cfs_pkg::ELEM_W-1] ? (~sum_sat + 1'b1) : sum_sat;
	assign pt_mag  = head.item.pt_elem[cfs_pkg::ELEM_W-1]
		? (~head.item.pt_elem + 1'b1) : head.item.pt_elem;

	// A shared multiplier serves the element squares and the two halves of SS*N; the denominator has its own product.
	always_comb begin
		unique case (state_q)
			S_SQ_LS: begin
				mul_a = ls_mag_q;
				mul_b = ls_mag_q;
			end
			S_MUL_LO: begin
				mul_a = ss_q[cfs_pkg::HALF_W-1:0];
				mul_b = cfs_pkg::HALF_W'(held_cnt_q);
			end
			S_MUL_HI: begin
				mul_a = ss_q[cfs_pkg::SS_W-1:cfs_pkg::HALF_W];
				mul_b = cfs_pkg::HALF_W'(held_cnt_q);
			end
			default: begin
				mul_a = pt_mag_q;
				mul_b = pt_mag_q;
			end
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	assign ls_add  = {1'b0, ls_acc_q} + {1'b0, prod_q};
	assign pt_add  = {1'b0, pt_acc_q} + {1'b0, prod_q};
	assign ss_add  = {1'b0, held_ss_q} + {1'b0, pt_acc_q};
	assign den_b   = mode_q ? (held_cnt_q - 1'b1) : held_cnt_q;
	assign acc_ext = cfs_pkg::SN_W'(ls_acc_q);
	assign diff    = (sn_q < acc_ext) ? '0 : (sn_q - acc_ext);

	assign root_req = '{
		start:    (state_q == S_SUB),
		dividend: mode_q ? {diff, 1'b0} : {1'b0, diff},
		divisor:  den_q
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= 1'b0;
			held_wp_q  <= 1'b0;
			held_cnt_q <= '0;
			held_ss_q  <= '0;
			ls_acc_q   <= '0;
			pt_acc_q   <= '0;
			ovf_q      <= 1'b0;
			last_q     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!empty) begin
						last_q  <= head.item.last_elem;
						state_q <= S_SQ_LS;
						if (head.first) begin
							held_wp_q  <= head.item.with_point;
							held_cnt_q <= cfs_pkg::HCNT_W'(head.item.point_count)
								+ cfs_pkg::HCNT_W'(head.item.with_point);
							held_ss_q  <= head.item.square_sum;
							ls_acc_q   <= '0;
							pt_acc_q   <= '0;
							ovf_q      <= sum_ovf;
						end else begin
							ovf_q <= ovf_q | sum_ovf;
						end
					end
				end
				S_SQ_LS: begin
					state_q <= S_ACC_LS;
				end
				S_ACC_LS: begin
					ls_acc_q <= ls_add[cfs_pkg::ACC_W] ? '1 : ls_add[cfs_pkg::ACC_W-1:0];
					ovf_q    <= ovf_q | ls_add[cfs_pkg::ACC_W];
					state_q  <= S_ACC_PT;
				end
				S_ACC_PT: begin
					if (held_wp_q) begin
						pt_acc_q <= pt_add[cfs_pkg::ACC_W] ? '1 : pt_add[cfs_pkg::ACC_W-1:0];
						ovf_q    <= ovf_q | pt_add[cfs_pkg::ACC_W];
					end
					state_q <= last_q ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					if (held_cnt_q < cfs_pkg::HCNT_W'(2)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						if (held_wp_q) begin
							ovf_q <= ovf_q | ss_add[cfs_pkg::SS_W];
						end
						state_q <= S_MUL_LO;
					end
				end
				S_MUL_LO: begin
					state_q <= S_MUL_HI;
				end
				S_MUL_HI: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					state_q <= S_SUB;
				end
				S_SUB: begin
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (root_rsp.done) begin
						ovf_q   <= ovf_q | root_rsp.overflow;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				ls_mag_q <= sum_mag;
				pt_mag_q <= pt_mag;
			end
			S_SQ_LS, S_ACC_LS: begin
				prod_q <= mul_p;
			end
			S_FIN: begin
				result_q <= '{cluster_size: '0, degenerate: 1'b1, saturated: ovf_q};
				if (held_wp_q) begin
					ss_q <= ss_add[cfs_pkg::SS_W] ? '1 : ss_add[cfs_pkg::SS_W-1:0];
				end else begin
					ss_q <= held_ss_q;
				end
				den_q <= held_cnt_q * den_b;
			end
			S_MUL_LO: begin
				prod_q <= mul_p;
			end
			S_MUL_HI: begin
				sn_q   <= cfs_pkg::SN_W'(prod_q);
				prod_q <= mul_p;
			end
			S_SUM: begin
				sn_q <= sn_q + {prod_q[cfs_pkg::SN_W-cfs_pkg::HALF_W-1:0],
					{cfs_pkg::HALF_W{1'b0}}};
			end
			S_ROOT: begin
				result_q <= '{cluster_size: root_rsp.root, degenerate: 1'b0,
					saturated: ovf_q | root_rsp.overflow};
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

endmodule

/* design/cluster_feature_size.sv */
// Each element passes the back-end states S_IDLE, S_SQ_LS, S_ACC_LS and S_ACC_PT; a four-entry
// queue in front absorbs bursts. The last element adds setup, the divider, an overflow check,
// the square root (skipped on overflow) and the result; under two points, setup gives the result.
// The result strobe is high for one cycle and the receiver cannot stall it.
// An asynchronous active-low reset empties the queue, selects the radius and
// makes the next element the first of a new vector.
module cluster_feature_size (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cfs_pkg::item_t    item,
	output logic              busy,
	output logic              done,
	output cfs_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);

	cfs_pkg::qentry_t    head;
	logic                empty;
	logic                pop;
	cfs_pkg::root_req_t  root_req;
	cfs_pkg::root_rsp_t  root_rsp;

	cfs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.pop    (pop),
		.head   (head),
		.empty  (empty)
	);

	cfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.root_req  (root_req),
		.root_rsp  (root_rsp),
		.done      (done),
		.result    (result)
	);

	cfs_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (root_req),
		.rsp    (root_rsp)
	);

endmodule

/* tb/cluster_feature_size_tb.sv */
`timescale 1ns / 1ps

module cluster_feature_size_tb;

	localparam bit METRIC_RADIUS   = 1'b0;
	localparam bit METRIC_DIAMETER = 1'b1;
	localparam int STALL_LIMIT     = 20000;
	localparam int SETTLE_CYCLES   = 400;
	localparam int RANDOM_ITEMS    = 125;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	cfs_pkg::item_t   item = '0;
	logic             busy;
	logic             done;
	cfs_pkg::result_t result;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic             cfg_data = 1'b0;

	cluster_feature_size u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	cfs_pkg::item_t   element_q[$];
	cfs_pkg::result_t expected_sizes[$];
	int               mismatches = 0;
	int               burst_left = 0;
	int               gap_left = 0;
	int               idle_cycles = 0;

	// Running state of the feature being sized.
	bit          metric_sel = METRIC_RADIUS;
	logic [63:0] ls_sq_acc = '0;
	logic [63:0] pt_sq_acc = '0;
	logic [24:0] eff_count = '0;
	logic [63:0] held_ss = '0;
	logic        with_pt = 1'b0;
	logic        first_elem = 1'b1;
	logic        clamped = 1'b0;

	function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
		logic [64:0] t;
		t = {1'b0, a} + {1'b0, b};
		if (t[64]) begin
			clamped = 1'b1;
			return '1;
		end
		return t[63:0];
	endfunction

	function automatic logic [63:0] square_of(logic signed [33:0] v);
		logic [33:0] m;
		m = (v < 0) ? -v : v;
		return 64'(m) * 64'(m);
	endfunction

	function automatic logic [31:0] int_sqrt(logic [63:0] x);
		logic [31:0] r;
		logic [31:0] t;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (32'd1 << b);
			if (64'(t) * 64'(t) <= x)
				r = t;
		end
		return r;
	endfunction

	task automatic absorb_element(input cfs_pkg::item_t it);
		logic signed [33:0] esum;
		logic [63:0]        ss_eff;
		logic [127:0]       radicand;
		logic [127:0]       quot;
		logic [49:0]        divisor;
		cfs_pkg::result_t   r;
		if (first_elem) begin
			with_pt = it.with_point;
			eff_count = {1'b0, it.point_count} + 25'(it.with_point);
			held_ss = it.square_sum;
			ls_sq_acc = '0;
			pt_sq_acc = '0;
			clamped = 1'b0;
		end
		esum = 34'(it.ls_elem);
		if (with_pt) begin
			esum = esum + 34'(it.pt_elem);
			if (esum > 34'sd2147483647) begin
				esum = 34'sd2147483647;
				clamped = 1'b1;
			end else if (esum < -34'sd2147483648) begin
				esum = -34'sd2147483648;
				clamped = 1'b1;
			end
			pt_sq_acc = sat_add(pt_sq_acc, square_of(34'(it.pt_elem)));
		end
		ls_sq_acc = sat_add(ls_sq_acc, square_of(esum));
		first_elem = it.last_elem;
		if (!it.last_elem)
			return;
		r = '0;
		if (eff_count < 2) begin
			r.degenerate = 1'b1;
		end else begin
			ss_eff = held_ss;
			if (with_pt)
				ss_eff = sat_add(ss_eff, pt_sq_acc);
			radicand = 128'(ss_eff) * 128'(eff_count);
			radicand = (radicand < 128'(ls_sq_acc)) ? '0 : radicand - 128'(ls_sq_acc);
			if (metric_sel == METRIC_DIAMETER) begin
				radicand = radicand << 1;
				divisor = 50'(eff_count) * 50'(eff_count - 25'd1);
			end else begin
				divisor = 50'(eff_count) * 50'(eff_count);
			end
			quot = radicand / 128'(divisor);
			if (quot[127:64] != '0) begin
				r.cluster_size = '1;
				clamped = 1'b1;
			end else begin
				r.cluster_size = int_sqrt(quot[63:0]);
			end
		end
		r.saturated = clamped;
		expected_sizes.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (start && !busy)
				absorb_element(item);
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (element_q.size() > 0) begin
					item <= element_q.pop_front();
					start <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 9) < 4) ? 0
							: $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic report(input string what, input cfs_pkg::result_t exp,
	                      input cfs_pkg::result_t act);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected %h/%b/%b got %h/%b/%b",
				$realtime, what, exp.cluster_size, exp.degenerate, exp.saturated,
				act.cluster_size, act.degenerate, act.saturated);
	endtask

	always @(posedge clk) begin
		cfs_pkg::result_t exp;
		if (arst_n && done) begin
			if (expected_sizes.size() == 0) begin
				report("unexpected result", '0, result);
			end else begin
				exp = expected_sizes.pop_front();
				if (result.cluster_size !== exp.cluster_size ||
				    result.degenerate !== exp.degenerate ||
				    result.saturated !== exp.saturated)
					report("result mismatch", exp, result);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic push_elem(input logic [31:0] ls, input logic [31:0] pt, input logic wp,
	                         input logic [23:0] n, input logic [63:0] ss, input logic last);
		cfs_pkg::item_t e;
		e.ls_elem = ls;
		e.pt_elem = pt;
		e.with_point = wp;
		e.point_count = n;
		e.square_sum = ss;
		e.last_elem = last;
		element_q.push_back(e);
	endtask

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return $signed($urandom) >>> $urandom_range(0, 28);
		endcase
	endfunction

	task automatic add_random_vectors(input int target);
		int          pushed;
		int          dims;
		logic [23:0] n;
		logic [63:0] ss;
		pushed = 0;
		while (pushed < target) begin
			dims = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 6);
			case ($urandom_range(0, 7))
				0: n = 24'($urandom_range(0, 2));
				1: n = 24'hFF_FFFF;
				2: n = 24'($urandom);
				default: n = 24'($urandom_range(2, 1000));
			endcase
			case ($urandom_range(0, 5))
				0: ss = '0;
				1: ss = '1;
				2: ss = {$urandom, $urandom};
				default: ss = {$urandom, $urandom} >> $urandom_range(0, 40);
			endcase
			for (int d = 0; d < dims; d++) begin
				if (d == 0)
					push_elem(rand_elem(), rand_elem(), 1'($urandom_range(0, 1)), n, ss,
						dims == 1);
				else
					push_elem(rand_elem(), rand_elem(), 1'($urandom_range(0, 1)),
						24'($urandom), {$urandom, $urandom}, d == dims - 1);
			end
			pushed += dims;
		end
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (element_q.size() != 0 || start || expected_sizes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_metric(input bit sel);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= sel;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		metric_sel = sel;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		write_metric(METRIC_RADIUS);
		// Counts around the degenerate bound, with and without the added point.
		push_elem(32'h0001_0000, 32'h0, 1'b0, 24'd0, 64'h0, 1'b1);
		push_elem(32'h0001_0000, 32'h0002_0000, 1'b1, 24'd1, 64'h3_0000_0000, 1'b1);
		push_elem(32'hFFFF_FFFF, 32'h5, 1'b0, 24'd1, 64'h1234, 1'b1);
		// Element sums that clamp at both ends of the signed range.
		push_elem(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 24'd5, 64'hFFFF_0000_0000_0000, 1'b0);
		push_elem(32'h0000_1000, 32'hFFFF_0000, 1'b0, 24'd0, 64'h0, 1'b1);
		push_elem(32'h8000_0000, 32'h8000_0000, 1'b1, 24'd3, 64'h8000_0000_0000_0000, 1'b1);
		// A square sum too small for the linear sum gives a zero size.
		push_elem(32'h7FFF_FFFF, 32'h0, 1'b0, 24'd4, 64'h0, 1'b1);
		// The added point's squares push the square sum past its range.
		push_elem(32'h1, 32'h7FFF_FFFF, 1'b1, 24'd10, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		// Five full-scale elements overflow the square accumulator.
		for (int d = 0; d < 5; d++)
			push_elem(32'h8000_0000, 32'h0, 1'b0, 24'd100, 64'hFFFF_FFFF_FFFF_FFFF, d == 4);
		push_elem(32'h0123_4567, 32'hFEDC_BA98, 1'b1, 24'hFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		push_elem(32'h8765_4321, 32'h0F0F_0F0F, 1'b0, 24'h0, 64'h0, 1'b1);
		push_elem(32'h0002_0000, 32'h0, 1'b0, 24'hFF_FFFF, 64'h0000_0400_0000_0000, 1'b1);
		push_elem(32'h0001_8000, 32'h0, 1'b0, 24'd3, 64'h0000_0010_0000_0000, 1'b0);
		push_elem(32'hFFFF_0000, 32'h0, 1'b0, 24'd0, 64'h0, 1'b0);
		push_elem(32'h0000_4000, 32'h0, 1'b0, 24'd0, 64'h0, 1'b1);
		drain();

		write_metric(METRIC_DIAMETER);
		// A full-scale square sum over two points overflows the diameter.
		push_elem(32'h0, 32'h0, 1'b0, 24'd2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		push_elem(32'h0003_0000, 32'h0001_0000, 1'b1, 24'd1, 64'h0000_0020_0000_0000, 1'b1);
		push_elem(32'h0001_0000, 32'h0, 1'b0, 24'd7, 64'h0000_0100_0000_0000, 1'b1);
		add_random_vectors(RANDOM_ITEMS);
		drain();

		write_metric(METRIC_RADIUS);
		add_random_vectors(RANDOM_ITEMS);
		drain();

		write_metric(METRIC_DIAMETER);
		add_random_vectors(RANDOM_ITEMS);
		drain();

		write_metric(METRIC_RADIUS);
		add_random_vectors(RANDOM_ITEMS);
		drain();

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
